FILE: rtl/kslt_pkg.sv
package kslt_pkg;

    // Fixed key matrix geometry of the payload: 8 by 8 key slots.
    localparam int KEY_SLOTS   = 64;
    localparam int KEY_IDX_W   = 6;
    localparam int COORD_W     = 3;
    localparam int DEB_W       = 16;

    // Defaults for the top level parameters.
    localparam int KEY_ROWS_DEF    = 8;
    localparam int KEY_COLUMNS_DEF = 8;
    localparam int AGE_BITS_DEF    = 16;

    // Reset value of the debounce register.
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd10;

    // Action codes of an input request.
    localparam logic [1:0] ACT_SCAN  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REACT_REL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_PRESENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SW_PRESENT  = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] row_bits;
        logic       lock_button;
        logic       lock_switch;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  column_drive;
        logic [63:0] shown_leds;
        logic [63:0] held_keys;
        logic        locked;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_LOCK,
        S_DONE
    } t_state;

    // Sequencer strobes used by the datapath.
    typedef struct packed {
        logic in_ready;
        logic issue;
        logic lock_step;
        logic out_load;
    } t_ctrl;

endpackage

FILE: rtl/keypad_scan_led_toggle_control_core.sv
// Channel  | Signals                              | Payload
// ---------+--------------------------------------+---------------------
// input    | i_in_valid / o_in_ready              | i_in_data  (t_in_item)
// output   | o_out_valid / i_out_ready            | o_out_data (t_out_item)
// config   | i_cfg_we, i_cfg_index                | i_cfg_data (64 bits)
//
// For a scan tick the sequencer walks the age memory one key per cycle through
// its write port and registered read port and one shared aging unit, then
// drains the sweep and steps the lock button. Clear and set actions skip the
// sweep and act at once. Reset is synchronous, active low, and
// needs no clearing pass. A result waits in the output register while the
// next request is accepted; a new result stalls only if that one is not taken.
module keypad_scan_led_toggle_control_core
    import kslt_pkg::*;
#(
    parameter int KEY_ROWS    = KEY_ROWS_DEF,
    parameter int KEY_COLUMNS = KEY_COLUMNS_DEF,
    parameter int AGE_BITS    = AGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(KEY_ROWS - 1);
    localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(KEY_COLUMNS - 1);

    t_state r_state, n_state;
    t_ctrl  ctrl;

    // Configuration registers.
    logic [63:0]      r_hold_mask, n_hold_mask;
    logic             r_react_rel, n_react_rel;
    logic [DEB_W-1:0] r_debounce, n_debounce;
    logic             r_btn_present, n_btn_present;
    logic             r_sw_present, n_sw_present;

    // Key and lock state.
    logic [KEY_SLOTS-1:0] r_held, n_held;
    logic [KEY_SLOTS-1:0] r_toggle, n_toggle;
    logic [KEY_SLOTS-1:0] r_shown, n_shown;
    logic [KEY_SLOTS-1:0] r_age_vld, n_age_vld;
    logic [COORD_W-1:0]   r_scol, n_scol;
    logic                 r_lock, n_lock;
    logic                 r_btn_held, n_btn_held;
    logic [AGE_BITS-1:0]  r_btn_age, n_btn_age;
    logic                 r_last_sw, n_last_sw;
    logic                 r_first, n_first;

    // Latched request and sweep counters.
    logic [1:0]         r_action, n_action;
    logic [7:0]         r_rows, n_rows;
    logic               r_btn, n_btn;
    logic               r_sw, n_sw;
    logic [COORD_W-1:0] r_row, n_row;
    logic [COORD_W-1:0] r_col, n_col;
    logic               r_p1_valid, n_p1_valid;
    logic [COORD_W-1:0] r_p1_row, n_p1_row;
    logic [COORD_W-1:0] r_p1_col, n_p1_col;

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic                 in_accept;
    logic                 last_key;
    logic [KEY_SLOTS-1:0] row_mask;
    logic [KEY_IDX_W-1:0] p1_key;
    logic [KEY_IDX_W-1:0] p1_led;
    logic                 key_seen;
    logic                 press;
    logic                 release_ev;
    logic                 new_bit;
    logic                 sw_active;
    logic                 lock_v;
    logic                 bheld_v;
    logic [AGE_BITS-1:0]  ram_rdata;
    logic                 ram_we;
    logic [AGE_BITS-1:0]  unit_age_in;
    logic                 unit_seen;
    logic [AGE_BITS-1:0]  unit_age_out;
    logic                 unit_expired;

    assign in_accept = i_in_valid && ctrl.in_ready;
    assign last_key  = (r_row == LAST_ROW) && (r_col == LAST_COL);
    assign p1_key    = {r_p1_row, r_p1_col};
    // Column 0 is the MSB of its row byte in the shown matrix.
    assign p1_led    = {r_p1_row, ~r_p1_col};
    assign key_seen  = (r_p1_col == r_scol) && r_rows[r_p1_row];
    assign sw_active = r_sw_present && r_sw;
    assign ram_we    = r_p1_valid;

    // Rows touched by the clear and set actions.
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            row_mask[i] = ((i >> 3) < KEY_ROWS);
        end
    end

    // The shared aging unit serves the key sweep and then the lock button.
    always_comb begin
        if (ctrl.lock_step) begin
            unit_age_in = r_btn_age;
            unit_seen   = r_btn;
        end else begin
            unit_age_in = r_age_vld[p1_key] ? ram_rdata : '0;
            unit_seen   = key_seen;
        end
    end

    kslt_age_unit #(
        .AGE_BITS(AGE_BITS)
    ) u_age_unit (
        .i_age      (unit_age_in),
        .i_seen     (unit_seen),
        .i_debounce (r_debounce),
        .o_age      (unit_age_out),
        .o_expired  (unit_expired)
    );

    kslt_ram #(
        .WIDTH(AGE_BITS),
        .DEPTH(KEY_SLOTS)
    ) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (p1_key),
        .i_wdata (unit_age_out),
        .i_raddr ({r_row, r_col}),
        .o_rdata (ram_rdata)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.action == ACT_SCAN) ? S_SWEEP : S_DONE;
                end
            end
            S_SWEEP: begin
                if (last_key) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_LOCK;
            end
            S_LOCK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer strobes.
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            S_IDLE:  ctrl.in_ready  = 1'b1;
            S_SWEEP: ctrl.issue     = 1'b1;
            S_DRAIN: ctrl           = '0;
            S_LOCK:  ctrl.lock_step = 1'b1;
            S_DONE:  ctrl.out_load  = !r_out_valid || i_out_ready;
            default: ctrl           = '0;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_hold_mask   = r_hold_mask;
        n_react_rel   = r_react_rel;
        n_debounce    = r_debounce;
        n_btn_present = r_btn_present;
        n_sw_present  = r_sw_present;
        n_held        = r_held;
        n_toggle      = r_toggle;
        n_shown       = r_shown;
        n_age_vld     = r_age_vld;
        n_scol        = r_scol;
        n_lock        = r_lock;
        n_btn_held    = r_btn_held;
        n_btn_age     = r_btn_age;
        n_last_sw     = r_last_sw;
        n_first       = r_first;
        n_action      = r_action;
        n_rows        = r_rows;
        n_btn         = r_btn;
        n_sw          = r_sw;
        n_row         = r_row;
        n_col         = r_col;
        n_p1_valid    = ctrl.issue;
        n_p1_row      = r_row;
        n_p1_col      = r_col;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        press         = 1'b0;
        release_ev    = 1'b0;
        new_bit       = r_toggle[p1_key];
        lock_v        = r_lock;
        bheld_v       = r_btn_held;

        // Configuration writes.
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HOLD_MASK:   n_hold_mask   = i_cfg_data;
                CFG_REACT_REL:   n_react_rel   = i_cfg_data[0];
                CFG_DEBOUNCE:    n_debounce    = i_cfg_data[DEB_W-1:0];
                CFG_BTN_PRESENT: n_btn_present = i_cfg_data[0];
                CFG_SW_PRESENT:  n_sw_present  = i_cfg_data[0];
                default:         n_hold_mask   = r_hold_mask;
            endcase
        end

        // Request capture; clear and set act at once.
        if (in_accept) begin
            n_action = i_in_data.action;
            n_rows   = i_in_data.row_bits;
            n_btn    = i_in_data.lock_button;
            n_sw     = i_in_data.lock_switch;
            n_row    = '0;
            n_col    = '0;
            case (i_in_data.action)
                ACT_CLEAR: n_shown = r_shown & ~row_mask;
                ACT_SET:   n_shown = r_shown | row_mask;
                default:   n_shown = r_shown;
            endcase
        end

        // Sweep address counters.
        if (ctrl.issue) begin
            if (r_col == LAST_COL) begin
                n_col = '0;
                n_row = r_row + COORD_W'(1);
            end else begin
                n_col = r_col + COORD_W'(1);
            end
        end

        // Per-key update: age write-back, press and release reactions.
        if (r_p1_valid) begin
            n_age_vld[p1_key] = 1'b1;
            press      = key_seen && !r_held[p1_key];
            release_ev = !key_seen && unit_expired && r_held[p1_key];
            if (press) begin
                n_held[p1_key] = 1'b1;
            end
            if (release_ev) begin
                n_held[p1_key] = 1'b0;
            end
            if ((press || release_ev) && !r_lock) begin
                if (r_hold_mask[p1_key]) begin
                    new_bit = press;
                end else if (press != r_react_rel) begin
                    new_bit = !r_toggle[p1_key];
                end
                n_toggle[p1_key] = new_bit;
                n_shown[p1_led]  = new_bit;
            end
        end

        // Column advance, lock button and lock switch.
        if (ctrl.lock_step) begin
            n_scol = (r_scol == LAST_COL) ? '0 : r_scol + COORD_W'(1);
            if (r_btn_present) begin
                n_btn_age = unit_age_out;
                if (r_btn && !r_btn_held) begin
                    bheld_v = 1'b1;
                    if (!r_react_rel && !sw_active) begin
                        lock_v = !lock_v;
                    end
                end
                if (unit_expired && bheld_v) begin
                    bheld_v = 1'b0;
                    if (r_react_rel && !sw_active) begin
                        lock_v = !lock_v;
                    end
                end
                n_btn_held = bheld_v;
            end
            if (r_first || (sw_active != r_last_sw)) begin
                n_last_sw = sw_active;
                lock_v    = sw_active;
            end
            n_lock  = lock_v;
            n_first = 1'b0;
        end

        // Output register.
        if (ctrl.out_load) begin
            n_out_valid        = 1'b1;
            n_out.column_drive = 8'(1) << r_scol;
            n_out.shown_leds   = r_shown;
            n_out.held_keys    = r_held;
            n_out.locked       = r_lock;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_hold_mask   <= '0;
            r_react_rel   <= 1'b0;
            r_debounce    <= DEBOUNCE_RESET;
            r_btn_present <= 1'b0;
            r_sw_present  <= 1'b0;
            r_held        <= '0;
            r_toggle      <= '0;
            r_shown       <= '0;
            r_age_vld     <= '0;
            r_scol        <= '0;
            r_lock        <= 1'b0;
            r_btn_held    <= 1'b0;
            r_btn_age     <= '0;
            r_last_sw     <= 1'b0;
            r_first       <= 1'b1;
            r_row         <= '0;
            r_col         <= '0;
            r_p1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_hold_mask   <= n_hold_mask;
            r_react_rel   <= n_react_rel;
            r_debounce    <= n_debounce;
            r_btn_present <= n_btn_present;
            r_sw_present  <= n_sw_present;
            r_held        <= n_held;
            r_toggle      <= n_toggle;
            r_shown       <= n_shown;
            r_age_vld     <= n_age_vld;
            r_scol        <= n_scol;
            r_lock        <= n_lock;
            r_btn_held    <= n_btn_held;
            r_btn_age     <= n_btn_age;
            r_last_sw     <= n_last_sw;
            r_first       <= n_first;
            r_row         <= n_row;
            r_col         <= n_col;
            r_p1_valid    <= n_p1_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_rows   <= n_rows;
        r_btn    <= n_btn;
        r_sw     <= n_sw;
        r_p1_row <= n_p1_row;
        r_p1_col <= n_p1_col;
        r_out    <= n_out;
    end

    assign o_in_ready  = ctrl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/kslt_ram.sv
module kslt_ram
    import kslt_pkg::*;
#(
    parameter int WIDTH = AGE_BITS_DEF,
    parameter int DEPTH = KEY_SLOTS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/kslt_age_unit.sv
module kslt_age_unit
    import kslt_pkg::*;
#(
    parameter int AGE_BITS = AGE_BITS_DEF
) (
    input  logic [AGE_BITS-1:0] i_age,
    input  logic                i_seen,
    input  logic [DEB_W-1:0]    i_debounce,
    output logic [AGE_BITS-1:0] o_age,
    output logic                o_expired
);

    localparam int CMP_W = (AGE_BITS > DEB_W) ? AGE_BITS : DEB_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic [CMP_W-1:0] age_ext;
    logic [CMP_W-1:0] deb_ext;

    // A seen key restarts its age; an unseen one ages and saturates.
    always_comb begin
        if (i_seen) begin
            o_age = '0;
        end else if (i_age == AGE_MAX) begin
            o_age = AGE_MAX;
        end else begin
            o_age = i_age + AGE_BITS'(1);
        end
        age_ext   = CMP_W'(o_age);
        deb_ext   = CMP_W'(i_debounce);
        o_expired = (age_ext > deb_ext);
    end

endmodule

FILE: test/keypad_panel_checker.sv
`timescale 1ns / 100ps
module keypad_panel_checker
    import kslt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int ROWS = KEY_ROWS_DEF;
    localparam int COLS = KEY_COLUMNS_DEF;
    localparam int unsigned AGE_CAP = (1 << AGE_BITS_DEF) - 1;
    localparam int MAX_PRINTED = 40;

    // Local copies of the configuration registers.
    logic [63:0]      hold_mask;
    logic             release_mode;
    logic [DEB_W-1:0] debounce_limit;
    logic             button_used;
    logic             switch_used;

    // Keypad, LED panel and lock state as the block should hold it.
    logic [63:0] key_down;
    int unsigned key_idle [KEY_SLOTS];
    logic [63:0] led_bits;
    logic [7:0]  panel_rows [8];
    int unsigned scan_col;
    logic        lock_on;
    logic        button_down;
    int unsigned button_idle;
    logic        prev_switch;
    logic        first_scan;

    // Predicted panels, oldest first, waiting for the block's results.
    t_out_item expected_panels [$];

    int fail_total = 0;
    int checked_total = 0;
    int pending_now = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;
    assign o_pending    = pending_now;

    // Every mismatch goes through here; printing stops after a while.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_total < MAX_PRINTED) begin
            $display("%t: %s: got %h, predicted %h", $realtime, what, got, want);
        end
        fail_total++;
    endtask

    function automatic int unsigned age_step(input int unsigned age);
        return (age >= AGE_CAP) ? AGE_CAP : age + 1;
    endfunction

    // A press or release of one key updates its LED bit unless locked.
    function automatic void key_reaction(input int unsigned r, input int unsigned c,
                                         input bit press);
        int unsigned k;
        k = r * 8 + c;
        if (lock_on) begin
            return;
        end
        if (hold_mask[k]) begin
            led_bits[k] = press;
        end else if (press != release_mode) begin
            led_bits[k] = ~led_bits[k];
        end
        panel_rows[r][7 - c] = led_bits[k];
    endfunction

    function automatic void reset_panel_model();
        hold_mask      = '0;
        release_mode   = 1'b0;
        debounce_limit = DEBOUNCE_RESET;
        button_used    = 1'b0;
        switch_used    = 1'b0;
        key_down       = '0;
        led_bits       = '0;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            key_idle[k] = 0;
        end
        for (int r = 0; r < 8; r++) begin
            panel_rows[r] = 8'h00;
        end
        scan_col    = 0;
        lock_on     = 1'b0;
        button_down = 1'b0;
        button_idle = 0;
        prev_switch = 1'b0;
        first_scan  = 1'b1;
    endfunction

    // Applies one request to the local state and returns the panel it reports.
    function automatic t_out_item predict_panel(input t_in_item req);
        t_out_item   res;
        logic [63:0] seen;
        logic        switch_on;
        int unsigned k;
        seen = '0;
        switch_on = switch_used && req.lock_switch;
        case (req.action)
            ACT_SCAN: begin
                // Keys seen in the driven column are refreshed, new ones pressed.
                for (int r = 0; r < ROWS; r++) begin
                    if (req.row_bits[r]) begin
                        k = r * 8 + scan_col;
                        seen[k] = 1'b1;
                        if (!key_down[k]) begin
                            key_reaction(r, scan_col, 1'b1);
                            key_down[k] = 1'b1;
                        end
                        key_idle[k] = 0;
                    end
                end
                // Unseen keys age; held keys quiet for too long are released.
                for (int r = 0; r < ROWS; r++) begin
                    for (int c = 0; c < COLS; c++) begin
                        k = r * 8 + c;
                        if (!seen[k]) begin
                            key_idle[k] = age_step(key_idle[k]);
                        end
                        if (key_idle[k] > debounce_limit && key_down[k]) begin
                            key_reaction(r, c, 1'b0);
                            key_down[k] = 1'b0;
                        end
                    end
                end
                scan_col = (scan_col + 1 >= COLS) ? 0 : scan_col + 1;
                // The lock button is debounced like a key and toggles the lock.
                if (button_used) begin
                    if (req.lock_button) begin
                        button_idle = 0;
                        if (!button_down) begin
                            button_down = 1'b1;
                            if (!release_mode && !switch_on) begin
                                lock_on = ~lock_on;
                            end
                        end
                    end else begin
                        button_idle = age_step(button_idle);
                    end
                    if (button_idle > debounce_limit && button_down) begin
                        button_down = 1'b0;
                        if (release_mode && !switch_on) begin
                            lock_on = ~lock_on;
                        end
                    end
                end
                // Switch edges, and the very first scan, force the lock level.
                if (first_scan || switch_on != prev_switch) begin
                    prev_switch = switch_on;
                    lock_on = switch_on;
                end
                first_scan = 1'b0;
            end
            ACT_CLEAR, ACT_SET: begin
                for (int r = 0; r < ROWS; r++) begin
                    panel_rows[r] = (req.action == ACT_CLEAR) ? 8'h00 : 8'hFF;
                end
            end
            default: begin
            end
        endcase
        res.column_drive = 8'(1 << scan_col);
        for (int r = 0; r < 8; r++) begin
            res.shown_leds[r * 8 +: 8] = panel_rows[r];
        end
        res.held_keys = key_down;
        res.locked = lock_on;
        return res;
    endfunction

    // Register writes, accepted requests and accepted results at each edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            reset_panel_model();
            expected_panels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HOLD_MASK:   hold_mask = i_cfg_data;
                    CFG_REACT_REL:   release_mode = i_cfg_data[0];
                    CFG_DEBOUNCE:    debounce_limit = i_cfg_data[DEB_W-1:0];
                    CFG_BTN_PRESENT: button_used = i_cfg_data[0];
                    CFG_SW_PRESENT:  switch_used = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_panels.push_back(predict_panel(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_panels.size() == 0) begin
                    report_mismatch("result with no request outstanding",
                                    i_out_data.shown_leds, '0);
                end else begin
                    want = expected_panels.pop_front();
                    if (i_out_data.column_drive !== want.column_drive) begin
                        report_mismatch("column_drive", 64'(i_out_data.column_drive),
                                        64'(want.column_drive));
                    end
                    if (i_out_data.shown_leds !== want.shown_leds) begin
                        report_mismatch("shown_leds", i_out_data.shown_leds,
                                        want.shown_leds);
                    end
                    if (i_out_data.held_keys !== want.held_keys) begin
                        report_mismatch("held_keys", i_out_data.held_keys, want.held_keys);
                    end
                    if (i_out_data.locked !== want.locked) begin
                        report_mismatch("locked", 64'(i_out_data.locked), 64'(want.locked));
                    end
                    checked_total++;
                end
            end
        end
        pending_now = expected_panels.size();
    end

endmodule

FILE: test/keypad_scan_led_toggle_control_core_test.sv
`timescale 1ns / 100ps
module keypad_scan_led_toggle_control_core_test;
    import kslt_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int LONG_HOLD = 400;
    localparam int IN_W = $bits(t_in_item);

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping: the keys physically held down, the lock inputs,
    // and the column the block drives next.
    logic [63:0] pressed = '0;
    logic        btn_level = 1'b0;
    logic        sw_level = 1'b0;
    int unsigned scan_col = 0;
    int          sent_total = 0;
    int          scan_total = 0;
    bit          idle_on = 1'b1;
    bit          stall_on = 1'b1;
    bit          hold_off_req = 1'b0;

    keypad_scan_led_toggle_control_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    keypad_panel_checker panel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake.
    initial begin
        #10_000_000;
        $display("Timed out with %0d results outstanding.", pending);
        $display("keypad_scan_led_toggle_control_core: mismatch");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (stall_on && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Offers one request and returns at the falling edge after it is taken.
    // Valid stays high so that a following request continues without a gap.
    task automatic send_req(input t_in_item req);
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        sent_total++;
        if (req.action == ACT_SCAN) begin
            scan_col = (scan_col + 1) % KEY_COLUMNS_DEF;
            scan_total++;
        end
    endtask

    task automatic send_scan(input logic [7:0] rows, input logic btn, input logic sw);
        t_in_item req;
        req.action = ACT_SCAN;
        req.row_bits = rows;
        req.lock_button = btn;
        req.lock_switch = sw;
        send_req(req);
    endtask

    // Non-scan requests carry random, unused fields.
    task automatic send_action(input logic [1:0] act);
        t_in_item req;
        req = t_in_item'(IN_W'($urandom));
        req.action = act;
        send_req(req);
    endtask

    task automatic idle_gap(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // Rewrites every register once the block is idle. Narrow registers get
    // junk in their unused bits, and the spare indexes get junk writes.
    task automatic set_mode(input logic [63:0] mask, input logic rel,
                            input logic [15:0] deb, input logic btn, input logic sw);
        logic [63:0] junk;
        wait_results();
        junk = {$urandom, $urandom};
        write_reg(CFG_HOLD_MASK, mask);
        write_reg(CFG_REACT_REL, {junk[63:1], rel});
        write_reg(CFG_DEBOUNCE, {junk[63:16], deb});
        write_reg(CFG_BTN_PRESENT, {junk[63:1], btn});
        write_reg(CFG_SW_PRESENT, {junk[63:1], sw});
        for (int k = int'(CFG_SW_PRESENT) + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly well-formed scanning of a slowly changing set of held keys,
    // with occasional bounce, panel actions and fully random requests.
    task automatic random_run(input int count);
        logic [7:0] rows;
        int         pick;
        for (int n = 0; n < count; n++) begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
                idle_gap($urandom_range(1, 17));
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                pressed[$urandom_range(0, 63)] ^= 1'b1;
            end else if (pick < 10) begin
                pressed = '0;
            end else if (pick < 11) begin
                pressed = {$urandom, $urandom} & {$urandom, $urandom};
            end
            if ($urandom_range(0, 19) == 0) begin
                btn_level = ~btn_level;
            end
            if ($urandom_range(0, 29) == 0) begin
                sw_level = ~sw_level;
            end
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                for (int r = 0; r < 8; r++) begin
                    rows[r] = pressed[r * 8 + scan_col];
                end
                if ($urandom_range(0, 9) == 0) begin
                    rows[$urandom_range(0, 7)] ^= 1'b1;
                end
                send_scan(rows, btn_level, sw_level);
            end else if (pick < 88) begin
                send_action(ACT_CLEAR);
            end else if (pick < 92) begin
                send_action(ACT_SET);
            end else if (pick < 94) begin
                send_action(ACT_NONE);
            end else begin
                send_req(t_in_item'(IN_W'($urandom)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: the first scan clears the lock with no switch fitted,
        // and button and switch inputs have no effect.
        send_scan(8'hFF, 1'b1, 1'b1);
        send_scan(8'h00, 1'b0, 1'b0);
        send_action(ACT_SET);
        send_scan(8'h81, 1'b1, 1'b0);
        send_action(ACT_CLEAR);
        send_action(ACT_NONE);
        send_scan(8'h01, 1'b0, 1'b1);
        random_run(110);

        // Click style on press, no debounce, button and switch both fitted.
        set_mode('0, 1'b0, 16'd0, 1'b1, 1'b1);
        send_scan(8'h00, 1'b1, 1'b0);
        send_scan(8'hFF, 1'b1, 1'b0);
        send_scan(8'h00, 1'b0, 1'b0);
        send_scan(8'h00, 1'b1, 1'b0);
        send_scan(8'h7E, 1'b0, 1'b1);
        send_scan(8'h00, 1'b1, 1'b1);
        send_scan(8'h00, 1'b0, 1'b0);
        send_scan(8'hFF, 1'b0, 1'b0);
        // A long hold-off on results stalls the block while requests keep being offered.
        hold_off_req = 1'b1;
        random_run(12);
        random_run(100);

        // Mixed styles reacting on release, short debounce, button only.
        set_mode({$urandom, $urandom}, 1'b1, 16'd3, 1'b1, 1'b0);
        random_run(60);
        wait_results();
        random_run(60);

        // Hold style everywhere with a debounce that never expires.
        set_mode('1, 1'b0, 16'hFFFF, 1'b1, 1'b1);
        send_scan(8'hFF, 1'b0, 1'b0);
        send_scan(8'h00, 1'b1, 1'b0);
        send_scan(8'h00, 1'b0, 1'b0);
        send_scan(8'h00, 1'b0, 1'b0);
        random_run(110);

        // Last stretch runs flat out on both sides.
        set_mode({$urandom, $urandom}, 1'b1, 16'd7, 1'b0, 1'b1);
        idle_on = 1'b0;
        stall_on = 1'b0;
        random_run(120);

        wait_results();
        repeat (80) @(posedge i_clk);
        @(negedge i_clk);
        $display("Sent %0d requests (%0d scan ticks) under five register settings.",
                 sent_total, scan_total);
        $display("Compared %0d panel results, with debounce from 0 to 65535 and both styles.",
                 checked);
        if (fail_count == 0) begin
            $display("keypad_scan_led_toggle_control_core: match");
        end else begin
            $display("keypad_scan_led_toggle_control_core: mismatch");
        end
        $finish;
    end

endmodule
